@@ design/lsts_pkg.sv @@
// ============================================================================
// lsts_pkg
// Shared constants, types and the slot hash of the longest target-sum
// subarray engine.
// ============================================================================
package lsts_pkg;

    // Longest array that is tracked; later elements only raise overflow.
    localparam int MAX_LEN    = 1024;
    // Width of the array elements.
    localparam int ELEM_BITS  = 16;
    // Width of prefix sums, keys and the target sum.
    localparam int SUM_BITS   = 26;
    // Width of the reported best length.
    localparam int LEN_BITS   = 11;
    // Hash table size. It is a power of two, so slot arithmetic wraps.
    localparam int SLOT_BITS  = 11;
    localparam int TABLE_SLOTS = 1 << SLOT_BITS;
    // Element counter, wide enough to hold MAX_LEN itself.
    localparam int IDX_BITS   = $clog2(MAX_LEN + 1);
    // Stored first index of a prefix, always below MAX_LEN.
    localparam int FIRST_BITS = $clog2(MAX_LEN);
    // Generation tag of a slot. Tag zero marks a slot that was swept.
    localparam int EPOCH_BITS = 8;
    // Multiplicative hash constant.
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [SUM_BITS-1:0]   key;
        logic [FIRST_BITS-1:0] first_index;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Home slot of a key: the low bits of the key times the hash constant.
    function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [SUM_BITS-1:0] key);
        logic [31:0] prod;
        prod = 32'(key) * HASH_MULT;
        return prod[SLOT_BITS-1:0];
    endfunction

endpackage

@@ design/lsts_if.sv @@
// ============================================================================
// lsts_if
// Valid/ready channels for array elements and for per-element results.
// ============================================================================
interface lsts_item_if;
    import lsts_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] element;
    logic                        last;

    modport source (output valid, element, last, input ready);
    modport sink   (input valid, element, last, output ready);
endinterface

interface lsts_result_if;
    import lsts_pkg::*;

    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] best_length;
    logic                final_res;
    logic                overflow;

    modport source (output valid, best_length, final_res, overflow, input ready);
    modport sink   (input valid, best_length, final_res, overflow, output ready);
endinterface

@@ design/lsts_ram.sv @@
// ============================================================================
// lsts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module lsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/longest_subarray_with_target_sum.sv @@
// ============================================================================
// longest_subarray_with_target_sum
// Streams the elements of signed arrays and reports, per element, the length
// of the longest subarray so far whose sum equals the programmed target.
// ============================================================================
// Usage: elements arrive one per transaction on the item channel, the final
// element of an array carrying last. Every element produces one transaction
// on the result channel with the running best length, a copy of last in
// final_res, and overflow once the array has run past MAX_LEN elements.
// The target sum is written through cfg_wr_en/cfg_wr_data while idle.
// One element is processed at a time. An accepted element passes the hash
// state, then linear probes of the slot table for the lookup and for the
// insert (each skipped when not needed), then the done state, which hands
// its result to the output register. An element past the length limit goes
// from acceptance straight to the done state. The single port pair of the
// slot memory is read and compared once per cycle while probing.
// After reset, and after every 255th array when the generation tag wraps,
// the whole slot memory is swept; item ready stays low meanwhile.
// The result sits in an output register, so the next element is accepted
// while a stalled receiver has not yet taken the previous result; a new
// result waits until that register is free.
// ============================================================================
module longest_subarray_with_target_sum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic signed [lsts_pkg::SUM_BITS-1:0] cfg_wr_data,
    lsts_item_if.sink                            item,
    lsts_result_if.source                        result
);
    import lsts_pkg::*;

    // Control and per-array state.
    state_t                state_reg, state_next;
    logic [SUM_BITS-1:0]   target_reg, target_next;
    logic [SUM_BITS-1:0]   prefix_reg, prefix_next;
    logic [IDX_BITS-1:0]   index_reg, index_next;
    logic [LEN_BITS-1:0]   best_reg, best_next;
    logic                  ovf_seen_reg, ovf_seen_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;

    // Per-element working registers.
    logic [SUM_BITS-1:0]   check_key_reg, check_key_next;
    logic                  do_lookup_reg, do_lookup_next;
    logic                  check_zero_reg, check_zero_next;
    logic                  last_reg, last_next;
    logic                  counted_reg, counted_next;
    logic                  insert_phase_reg, insert_phase_next;
    logic [SLOT_BITS-1:0]  ins_hash_reg, ins_hash_next;
    logic [SLOT_BITS-1:0]  probe_addr_reg, probe_addr_next;
    logic [SLOT_BITS-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [SLOT_BITS-1:0]  clear_cnt_reg, clear_cnt_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [LEN_BITS-1:0]   out_best_reg, out_best_next;
    logic                  out_final_reg, out_final_next;
    logic                  out_ovf_reg, out_ovf_next;

    // Slot memory access.
    logic                  ram_wr_en;
    logic [SLOT_BITS-1:0]  ram_wr_addr;
    slot_t                 ram_wr_slot;
    logic                  ram_rd_en;
    logic [SLOT_BITS-1:0]  ram_rd_addr;
    logic [$bits(slot_t)-1:0] ram_rd_data;
    slot_t                 rd_slot;

    // Datapath terms.
    logic [SUM_BITS-1:0]   elem_ext;
    logic [SUM_BITS-1:0]   pref_sum;
    logic [SUM_BITS:0]     check_diff;
    logic [SLOT_BITS-1:0]  lookup_hash;
    logic [SLOT_BITS-1:0]  insert_hash;
    logic [SUM_BITS-1:0]   probe_key;
    logic                  slot_live;
    logic                  key_hit;
    logic                  last_probe;
    logic [IDX_BITS-1:0]   hit_len;
    logic [IDX_BITS-1:0]   index_inc;

    lsts_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_slot),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_slot = slot_t'(ram_rd_data);

    // Prefix update and lookup key, both formed in the acceptance cycle. The
    // difference is one bit wider so that a key outside the signed range of
    // a prefix can be recognized and skipped.
    assign elem_ext   = {{(SUM_BITS - ELEM_BITS){item.element[ELEM_BITS-1]}}, item.element};
    assign pref_sum   = prefix_reg + elem_ext;
    assign check_diff = {pref_sum[SUM_BITS-1], pref_sum} - {target_reg[SUM_BITS-1], target_reg};

    assign lookup_hash = slot_hash(check_key_reg);
    assign insert_hash = slot_hash(prefix_reg);

    // A slot is live only when it was written in the current generation.
    assign probe_key  = insert_phase_reg ? prefix_reg : check_key_reg;
    assign slot_live  = (rd_slot.tag == epoch_reg);
    assign key_hit    = slot_live && (rd_slot.key == probe_key);
    assign last_probe = (probe_cnt_reg == {SLOT_BITS{1'b1}});
    assign hit_len    = index_reg - IDX_BITS'(rd_slot.first_index);
    assign index_inc  = index_reg + IDX_BITS'(1);

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.best_length = out_best_reg;
    assign result.final_res   = out_final_reg;
    assign result.overflow    = out_ovf_reg;

    always_comb
    begin
        state_next        = state_reg;
        target_next       = cfg_wr_en ? cfg_wr_data : target_reg;
        prefix_next       = prefix_reg;
        index_next        = index_reg;
        best_next         = best_reg;
        ovf_seen_next     = ovf_seen_reg;
        epoch_next        = epoch_reg;
        check_key_next    = check_key_reg;
        do_lookup_next    = do_lookup_reg;
        check_zero_next   = check_zero_reg;
        last_next         = last_reg;
        counted_next      = counted_reg;
        insert_phase_next = insert_phase_reg;
        ins_hash_next     = ins_hash_reg;
        probe_addr_next   = probe_addr_reg;
        probe_cnt_next    = probe_cnt_reg;
        clear_cnt_next    = clear_cnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_best_next     = out_best_reg;
        out_final_next    = out_final_reg;
        out_ovf_next      = out_ovf_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = probe_addr_reg;
        ram_wr_slot = '{tag: epoch_reg, key: prefix_reg,
                        first_index: index_reg[FIRST_BITS-1:0]};
        ram_rd_en   = 1'b0;
        ram_rd_addr = probe_addr_reg + SLOT_BITS'(1);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every slot back to the never-live tag.
                ram_wr_en      = 1'b1;
                ram_wr_addr    = clear_cnt_reg;
                ram_wr_slot    = '0;
                clear_cnt_next = clear_cnt_reg + SLOT_BITS'(1);
                if (clear_cnt_reg == {SLOT_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item.valid)
                begin
                    last_next = item.last;
                    if (index_reg >= IDX_BITS'(MAX_LEN))
                    begin
                        // Past the length limit: nothing but the flag moves.
                        ovf_seen_next = 1'b1;
                        counted_next  = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        prefix_next     = pref_sum;
                        check_key_next  = check_diff[SUM_BITS-1:0];
                        check_zero_next = (check_diff == '0);
                        do_lookup_next  = (check_diff != '0) &&
                                          (check_diff[SUM_BITS] == check_diff[SUM_BITS-1]);
                        counted_next    = 1'b1;
                        state_next      = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                // The whole prefix matches the target: the empty prefix sits
                // at index minus one.
                if (check_zero_reg && (LEN_BITS'(index_inc) > best_reg))
                begin
                    best_next = LEN_BITS'(index_inc);
                end
                ins_hash_next  = insert_hash;
                probe_cnt_next = '0;
                if (do_lookup_reg)
                begin
                    ram_rd_en         = 1'b1;
                    ram_rd_addr       = lookup_hash;
                    probe_addr_next   = lookup_hash;
                    insert_phase_next = 1'b0;
                    state_next        = ST_PROBE;
                end
                else if (prefix_reg != '0)
                begin
                    ram_rd_en         = 1'b1;
                    ram_rd_addr       = insert_hash;
                    probe_addr_next   = insert_hash;
                    insert_phase_next = 1'b1;
                    state_next        = ST_PROBE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PROBE:
            begin
                if (!insert_phase_reg)
                begin
                    if (key_hit && (LEN_BITS'(hit_len) > best_reg))
                    begin
                        best_next = LEN_BITS'(hit_len);
                    end
                    if (!slot_live || key_hit || last_probe)
                    begin
                        // Lookup finished; start the insert probe right away unless the prefix is zero.
                        if (prefix_reg != '0)
                        begin
                            ram_rd_en         = 1'b1;
                            ram_rd_addr       = ins_hash_reg;
                            probe_addr_next   = ins_hash_reg;
                            probe_cnt_next    = '0;
                            insert_phase_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        ram_rd_en       = 1'b1;
                        probe_addr_next = ram_rd_addr;
                        probe_cnt_next  = probe_cnt_reg + SLOT_BITS'(1);
                    end
                end
                else
                begin
                    if (!slot_live)
                    begin
                        // First free slot: record where this prefix appeared.
                        ram_wr_en  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (key_hit || last_probe)
                    begin
                        // Already known, or the table is full.
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ram_rd_en       = 1'b1;
                        probe_addr_next = ram_rd_addr;
                        probe_cnt_next  = probe_cnt_reg + SLOT_BITS'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = best_reg;
                    out_final_next = last_reg;
                    out_ovf_next   = ovf_seen_reg;
                    if (counted_reg)
                    begin
                        index_next = index_inc;
                    end
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        // Close the array; a new generation retires all slots.
                        prefix_next   = '0;
                        index_next    = '0;
                        best_next     = '0;
                        ovf_seen_next = 1'b0;
                        if (epoch_reg == {EPOCH_BITS{1'b1}})
                        begin
                            epoch_next     = EPOCH_BITS'(1);
                            clear_cnt_next = '0;
                            state_next     = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_BITS'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            target_reg       <= '0;
            prefix_reg       <= '0;
            index_reg        <= '0;
            best_reg         <= '0;
            ovf_seen_reg     <= 1'b0;
            epoch_reg        <= EPOCH_BITS'(1);
            check_key_reg    <= '0;
            do_lookup_reg    <= 1'b0;
            check_zero_reg   <= 1'b0;
            last_reg         <= 1'b0;
            counted_reg      <= 1'b0;
            insert_phase_reg <= 1'b0;
            ins_hash_reg     <= '0;
            probe_addr_reg   <= '0;
            probe_cnt_reg    <= '0;
            clear_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_best_reg     <= '0;
            out_final_reg    <= 1'b0;
            out_ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            target_reg       <= target_next;
            prefix_reg       <= prefix_next;
            index_reg        <= index_next;
            best_reg         <= best_next;
            ovf_seen_reg     <= ovf_seen_next;
            epoch_reg        <= epoch_next;
            check_key_reg    <= check_key_next;
            do_lookup_reg    <= do_lookup_next;
            check_zero_reg   <= check_zero_next;
            last_reg         <= last_next;
            counted_reg      <= counted_next;
            insert_phase_reg <= insert_phase_next;
            ins_hash_reg     <= ins_hash_next;
            probe_addr_reg   <= probe_addr_next;
            probe_cnt_reg    <= probe_cnt_next;
            clear_cnt_reg    <= clear_cnt_next;
            out_valid_reg    <= out_valid_next;
            out_best_reg     <= out_best_next;
            out_final_reg    <= out_final_next;
            out_ovf_reg      <= out_ovf_next;
        end
    end

endmodule

@@ design/lsts_checker.sv @@
// ============================================================================
// lsts_checker
// Port-level assertions for the longest target-sum subarray engine.
// ============================================================================
module lsts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [lsts_pkg::LEN_BITS-1:0] result_best_length,
    input logic                          result_final_res,
    input logic                          result_overflow
);
    import lsts_pkg::*;

    // A stalled result must stay offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_best_length) &&
            $stable(result_final_res) && $stable(result_overflow))
        else $error("result changed while stalled");

    // Elements are processed one at a time: no acceptance right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("element accepted while another is in progress");

    // A subarray can never be longer than the tracked array.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_best_length <= LEN_BITS'(MAX_LEN)))
        else $error("best length beyond the array limit");

    // The slot table is swept after reset before any element is taken.
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !item_ready && !result_valid)
        else $error("block ready before the slot sweep");

endmodule

bind longest_subarray_with_target_sum lsts_checker u_lsts_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_best_length (result.best_length),
    .result_final_res   (result.final_res),
    .result_overflow    (result.overflow)
);

@@ tb/sv/longest_subarray_with_target_sum_tb.sv @@
// ============================================================================
// longest_subarray_with_target_sum_tb
// Self-checking bench for the streaming longest target-sum subarray engine.
// A directed table walks reset behavior, key range limits and the zero-prefix
// rule. Random arrays follow, shaped so that segments hit the target, and
// then one array that runs past the length limit. Every result is compared
// with a behavioral tracker of prefix sums, or with a typed directed row.
// ============================================================================
module longest_subarray_with_target_sum_tb;
    import lsts_pkg::*;

    // Both sides draw their wait per transaction from this range.
    localparam int GAP_MAX          = 17;
    // Pause before a target write, once all results are home. Every element
    // yields a result, so no element is in progress by then.
    localparam int SETTLE_CYCLES    = 8;
    // Quiet time at the end, to catch stray results.
    localparam int DRAIN_CYCLES     = 32;
    // Long stall of the result sink, started when this many results are in.
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    // Includes the slot sweeps after reset and after each tag wrap.
    localparam int CYCLE_LIMIT      = 500000;

    localparam logic signed [SUM_BITS-1:0]  TARGET_MIN = SUM_BITS'(-(2 ** (SUM_BITS - 1)));
    localparam logic signed [SUM_BITS-1:0]  TARGET_MAX = SUM_BITS'(2 ** (SUM_BITS - 1) - 1);
    localparam logic signed [ELEM_BITS-1:0] ELEM_MIN   = ELEM_BITS'(-(2 ** (ELEM_BITS - 1)));
    localparam logic signed [ELEM_BITS-1:0] ELEM_MAX   = ELEM_BITS'(2 ** (ELEM_BITS - 1) - 1);
    // Lookup keys outside [-SUM_HALF, SUM_HALF) cannot be held and match nothing.
    localparam longint SUM_HALF   = longint'(1) << (SUM_BITS - 1);
    localparam int     LEN_CEIL   = (1 << LEN_BITS) - 1;

    // One result transaction as the engine reports it.
    typedef struct packed {
        logic [LEN_BITS-1:0] best_length;
        logic                final_res;
        logic                overflow;
    } outcome_t;

    // One row of the directed table. Where typed is set, the wanted result is
    // written out in the row; otherwise the tracker supplies it.
    typedef struct packed {
        logic                        write_target;
        logic signed [SUM_BITS-1:0]  target;
        logic signed [ELEM_BITS-1:0] element;
        logic                        last;
        logic                        typed;
        logic [LEN_BITS-1:0]         want_length;
        logic                        want_overflow;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic signed [SUM_BITS-1:0] cfg_wr_data;

    lsts_item_if   item_ch ();
    lsts_result_if result_ch ();

    longest_subarray_with_target_sum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prefix-sum tracker. The first index of every nonzero prefix sum of the
    // current array lives in an associative array keyed by the signed sum.
    // At most MAX_LEN sums are ever stored, half the slot count, so the
    // engine's table can never be full and its probe order never shows.
    // ------------------------------------------------------------------------
    logic signed [SUM_BITS-1:0] target_reg;
    logic signed [SUM_BITS-1:0] running_sum;
    int                         elems_taken;
    int                         best_len;
    bit                         overflow_flag;
    int                         first_seen_at [int];

    // Results owed by the engine, oldest first.
    outcome_t awaited_results [$];

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    bit sender_calm  = 1'b0;
    bit pause_pending = 1'b0;

    function automatic void clear_tracker();
        running_sum   = '0;
        elems_taken   = 0;
        best_len      = 0;
        overflow_flag = 1'b0;
        first_seen_at.delete();
    endfunction

    // Advances the tracker by one element and returns the result it owes.
    function automatic outcome_t track_element(input logic signed [ELEM_BITS-1:0] elem,
                                               input logic is_last);
        logic signed [SUM_BITS-1:0] new_sum;
        longint                     key_gap;
        outcome_t                   res;
        if (elems_taken >= MAX_LEN)
        begin
            // Past the length limit the element is dropped, but the flag
            // sticks until the array ends.
            overflow_flag = 1'b1;
        end
        else
        begin
            new_sum = running_sum + {{(SUM_BITS - ELEM_BITS){elem[ELEM_BITS-1]}}, elem};
            key_gap = longint'(new_sum) - longint'(target_reg);
            if (key_gap == 0)
            begin
                // The empty prefix (sum zero, index minus one) matches.
                if (elems_taken + 1 > best_len)
                    best_len = elems_taken + 1;
            end
            else if (key_gap >= -SUM_HALF && key_gap < SUM_HALF)
            begin
                if (first_seen_at.exists(int'(key_gap)))
                begin
                    if (elems_taken - first_seen_at[int'(key_gap)] > best_len)
                        best_len = elems_taken - first_seen_at[int'(key_gap)];
                end
            end
            // Only the first appearance of a sum counts; zero is never stored.
            if (new_sum != 0 && !first_seen_at.exists(int'(new_sum)))
                first_seen_at[int'(new_sum)] = elems_taken;
            running_sum = new_sum;
            elems_taken++;
        end
        res.best_length = (best_len > LEN_CEIL) ? LEN_BITS'(LEN_CEIL) : LEN_BITS'(best_len);
        res.final_res   = is_last;
        res.overflow    = overflow_flag;
        if (is_last)
            clear_tracker();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got_val,
                                   input logic [31:0] want_val);
        mismatches++;
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 results_seen, what, got_val, want_val);
    endtask

    task automatic check_result(input outcome_t got);
        outcome_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected transaction, best_length",
                            32'(got.best_length), 32'(0));
            return;
        end
        want = awaited_results.pop_front();
        if (got.best_length !== want.best_length)
            report_mismatch("best_length", 32'(got.best_length), 32'(want.best_length));
        if (got.final_res !== want.final_res)
            report_mismatch("final_res", 32'(got.final_res), 32'(want.final_res));
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    endtask

    // ------------------------------------------------------------------------
    // Result sink. Ready is lowered for a random number of cycles before each
    // transaction. Calm stretches of 32 results take every transaction at
    // once. Once, deep inside the long array, the sink holds off for a long
    // stretch so that the output register fills and item ready drops while
    // the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        bit calm;
        calm = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (results_seen == LONG_HOLD_AT)
                stall = LONG_HOLD_CYCLES;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            // Outputs are sampled at the edge, before the engine updates them.
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            check_result('{result_ch.best_length, result_ch.final_res, result_ch.overflow});
            results_seen++;
        end
    end

    // Hard stop in case the engine hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Element source. Called at a rising edge. Valid stays high from one
    // transaction to the next when no gap is drawn; any waiting caller lowers
    // it first through wait_for_drain.
    // ------------------------------------------------------------------------
    task automatic send_element(input logic signed [ELEM_BITS-1:0] elem, input logic is_last,
                                input logic use_typed, input outcome_t typed_want);
        int       gap;
        outcome_t predicted;
        outcome_t owed;
        gap = sender_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.element <= elem;
        item_ch.last    <= is_last;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        predicted = track_element(elem, is_last);
        owed = use_typed ? typed_want : predicted;
        awaited_results = {awaited_results, owed};
    endtask

    // Stops offering and waits until the engine has returned every result.
    task automatic wait_for_drain();
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_target(input logic signed [SUM_BITS-1:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        target_reg = value;
    endtask

    // Mostly small values so that sums meet small targets, multiples of 2048
    // so that keys share a home slot and probe chains grow, and some extremes.
    function automatic int draw_element();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return int'($urandom_range(0, 8)) - 4;
        if (pick < 75)
            return (int'($urandom_range(0, 31)) - 16) * 2048;
        if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return int'(ELEM_MIN);
                1:       return int'(ELEM_MAX);
                2:       return 0;
                default: return -1;
            endcase
        end
        return int'(ELEM_MIN) + int'($urandom_range(0, 65535));
    endfunction

    function automatic int draw_array_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 1;
        if (pick < 8)
            return $urandom_range(2, 6);
        return $urandom_range(7, 24);
    endfunction

    // Sends one array. Most arrays get one segment whose last element is
    // chosen so that the segment sums to the target, which makes hits common.
    task automatic send_array(input int len);
        int     vals [$];
        int     seg_lo;
        int     seg_hi;
        longint seg_sum;
        longint needed;
        sender_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            vals = {vals, draw_element()};
        if ($urandom_range(0, 9) < 7)
        begin
            seg_hi  = $urandom_range(0, len - 1);
            seg_lo  = $urandom_range(0, seg_hi);
            seg_sum = 0;
            for (int i = seg_lo; i < seg_hi; i++)
                seg_sum += vals[i];
            needed = longint'(target_reg) - seg_sum;
            if (needed >= ELEM_MIN && needed <= ELEM_MAX)
                vals[seg_hi] = int'(needed);
        end
        for (int i = 0; i < len; i++)
        begin
            // A requested pause falls in the middle of an array, so the
            // engine must keep its state across the idle stretch.
            if (pause_pending && i > 0 && i == len / 2)
            begin
                wait_for_drain();
                pause_pending = 1'b0;
            end
            send_element(ELEM_BITS'(vals[i]), i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic send_arrays(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            len = draw_array_len();
            if (len > budget - sent)
                len = budget - sent;
            send_array(len);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [23] = '{
        //  wr    target        element        last  typed length  ovf
        // A zero element under the reset target matches the empty prefix.
        '{1'b0, 26'sd0,       16'sd0,        1'b0, 1'b1, 11'd1, 1'b0},
        '{1'b0, 26'sd0,       16'sd5,        1'b1, 1'b1, 11'd1, 1'b0},
        // Small target with a mix of hits through stored and empty prefixes.
        '{1'b1, 26'sd7,       16'sd3,        1'b0, 1'b1, 11'd0, 1'b0},
        '{1'b0, 26'sd7,       16'sd4,        1'b0, 1'b1, 11'd2, 1'b0},
        '{1'b0, 26'sd7,       -16'sd2,       1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd7,       16'sd9,        1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd7,       -16'sd7,       1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd7,       16'sd7,        1'b1, 1'b0, 11'd0, 1'b0},
        // Lookup key above the representable range matches nothing.
        '{1'b1, TARGET_MIN,   ELEM_MAX,      1'b1, 1'b1, 11'd0, 1'b0},
        // Lookup key below the range, then exactly at its lower end.
        '{1'b1, TARGET_MAX,   ELEM_MIN,      1'b0, 1'b1, 11'd0, 1'b0},
        '{1'b0, TARGET_MAX,   ELEM_MAX,      1'b1, 1'b1, 11'd0, 1'b0},
        // Extreme elements that equal the target on their own.
        '{1'b1, -26'sd32768,  ELEM_MIN,      1'b1, 1'b1, 11'd1, 1'b0},
        '{1'b1, 26'sd32767,   ELEM_MAX,      1'b0, 1'b1, 11'd1, 1'b0},
        '{1'b0, 26'sd32767,   16'sd0,        1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd32767,   16'sd1,        1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd32767,   -16'sd1,       1'b1, 1'b0, 11'd0, 1'b0},
        // The prefix returns to zero twice; zero is never stored, yet the
        // empty prefix keeps matching.
        '{1'b1, 26'sd0,       16'sd3,        1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd0,       -16'sd3,       1'b0, 1'b1, 11'd2, 1'b0},
        '{1'b0, 26'sd0,       16'sd5,        1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, 26'sd0,       -16'sd5,       1'b1, 1'b1, 11'd4, 1'b0},
        // All-ones target and alternating bit patterns.
        '{1'b1, -26'sd1,      -16'sd1,       1'b0, 1'b1, 11'd1, 1'b0},
        '{1'b0, -26'sd1,      16'sh5555,     1'b0, 1'b0, 11'd0, 1'b0},
        '{1'b0, -26'sd1,      16'shAAAA,     1'b1, 1'b0, 11'd0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;
        int        long_vals [$];
        longint    long_total;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.element <= '0;
        item_ch.last    <= 1'b0;
        target_reg = '0;
        clear_tracker();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The first rows run under the reset value of the target.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.write_target)
                set_target(row.target);
            sender_calm = ($urandom_range(0, 1) == 1);
            send_element(row.element, row.last, row.typed,
                         '{row.want_length, row.last, row.want_overflow});
        end

        // Zero target, then a small one with an idle pause inside an array,
        // then a wide target with the same shaping.
        set_target('0);
        send_arrays(15);
        set_target(SUM_BITS'(int'($urandom_range(0, 40)) - 20));
        pause_pending = 1'b1;
        send_arrays(15);
        set_target(SUM_BITS'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20));
        send_arrays(10);

        // Many one-element arrays. Together with the arrays above this runs
        // past 255 arrays, so the slot tag wraps and a sweep takes place.
        set_target(SUM_BITS'(int'($urandom_range(0, 16)) - 8));
        repeat (250)
            send_array(1);

        // One array of MAX_LEN elements whose total is the target, so the
        // best length reaches MAX_LEN at its last tracked element. Two more
        // elements follow past the limit and raise overflow.
        long_total = 0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            long_vals = {long_vals, draw_element()};
            long_total += long_vals[i];
        end
        set_target(SUM_BITS'(long_total));
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i % 64 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            send_element(ELEM_BITS'(long_vals[i]), 1'b0, 1'b0, '0);
        end
        send_element(ELEM_BITS'(draw_element()), 1'b0, 1'b0, '0);
        send_element(ELEM_BITS'(draw_element()), 1'b1, 1'b0, '0);

        // State must be clean again after the overflowing array.
        set_target(SUM_BITS'(int'($urandom_range(0, 10)) - 5));
        send_arrays(10);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
